>>> sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C register-transfer master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// Item kinds on the input channel
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_WBYTE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_PHASE_TICKS   = 2'd1;
	localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd2;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
	localparam logic [9:0] ACK_TIMEOUT_RST = 10'd300;

	// Bus sequencer phases
	localparam logic [4:0] PH_IDLE      = 5'd0;
	localparam logic [4:0] PH_ST0       = 5'd1;
	localparam logic [4:0] PH_ST1       = 5'd2;
	localparam logic [4:0] PH_ST2       = 5'd3;
	localparam logic [4:0] PH_TX_SET    = 5'd4;
	localparam logic [4:0] PH_TX_HI     = 5'd5;
	localparam logic [4:0] PH_TX_LO     = 5'd6;
	localparam logic [4:0] PH_AK_REL    = 5'd7;
	localparam logic [4:0] PH_AK_HI     = 5'd8;
	localparam logic [4:0] PH_AK_POLL   = 5'd9;
	localparam logic [4:0] PH_WAIT_BYTE = 5'd10;
	localparam logic [4:0] PH_RX_LO     = 5'd11;
	localparam logic [4:0] PH_RX_HI     = 5'd12;
	localparam logic [4:0] PH_RX_SMP    = 5'd13;
	localparam logic [4:0] PH_MA0       = 5'd14;
	localparam logic [4:0] PH_MA1       = 5'd15;
	localparam logic [4:0] PH_MA2       = 5'd16;
	localparam logic [4:0] PH_SP0       = 5'd17;
	localparam logic [4:0] PH_SP1       = 5'd18;
	localparam logic [4:0] PH_SP2       = 5'd19;
	localparam logic [4:0] PH_SP_END    = 5'd20;

	// Which byte of the transfer is on the bus
	localparam logic [2:0] SG_ADDR_W = 3'd0;
	localparam logic [2:0] SG_REG_HI = 3'd1;
	localparam logic [2:0] SG_REG_LO = 3'd2;
	localparam logic [2:0] SG_DATA_W = 3'd3;
	localparam logic [2:0] SG_ADDR_R = 3'd4;
	localparam logic [2:0] SG_DATA_R = 3'd5;

	typedef struct packed {
		logic [6:0] slave_address;
		logic [7:0] phase_ticks;
		logic [9:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        sda_in;
		logic        is_read;
		logic [15:0] register_address;
		logic [7:0]  byte_count;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic [4:0]  phase;
		logic [3:0]  bit_index;
		logic [7:0]  shift_byte;
		logic [7:0]  bytes_left;
		logic [9:0]  ack_polls;
		logic [7:0]  delay_left;
		logic [15:0] held_register;
		logic        read_flag;
		logic        scl_level;
		logic        sda_level;
		logic [2:0]  stage;
		logic        fail_flag;
	} state_t;

	typedef struct packed {
		logic       scl;
		logic       sda_release;
		logic       busy_res;
		logic       need_byte;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       done_res;
		logic       failed;
	} res_t;

	localparam state_t STATE_RST = '{
		phase: PH_IDLE, bit_index: 4'd0, shift_byte: 8'd0, bytes_left: 8'd0,
		ack_polls: 10'd0, delay_left: 8'd0, held_register: 16'd0, read_flag: 1'b0,
		scl_level: 1'b1, sda_level: 1'b1, stage: SG_ADDR_W, fail_flag: 1'b0
	};

endpackage

>>> sv/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic of the bus sequencer for one input beat.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::cfg_t   cfg,
	input  i2cm_pkg::item_t  item,
	input  i2cm_pkg::state_t st,
	output i2cm_pkg::state_t ns,
	output i2cm_pkg::res_t   res
);
	import i2cm_pkg::*;

	logic [7:0] reload;
	logic [3:0] bit_inc;
	logic [7:0] bytes_dec;
	logic [7:0] rx_shift;
	logic       rb_valid;
	logic [7:0] rb_data;
	logic       done;
	logic       fail;

	// Enter a phase and load its wait count
	function automatic state_t go_to(state_t s, logic [4:0] nxt, logic [7:0] rl);
		state_t r;
		r = s;
		r.phase = nxt;
		r.delay_left = rl;
		return r;
	endfunction

	assign reload    = (cfg.phase_ticks == 8'd0) ? 8'd0 : cfg.phase_ticks - 8'd1;
	assign bit_inc   = st.bit_index + 4'd1;
	assign bytes_dec = (st.bytes_left != 8'd0) ? st.bytes_left - 8'd1 : 8'd0;
	assign rx_shift  = {st.shift_byte[6:0], item.sda_in};

	// Advance the sequencer
	always_comb begin
		ns = st;
		rb_valid = 1'b0;
		rb_data = 8'd0;
		done = 1'b0;
		fail = 1'b0;
		if (item.mode == MODE_START && st.phase == PH_IDLE) begin
			ns.read_flag = item.is_read;
			ns.held_register = item.register_address;
			ns.bytes_left = item.byte_count;
			ns.shift_byte = {cfg.slave_address, 1'b0};
			ns.bit_index = 4'd0;
			ns.ack_polls = 10'd0;
			ns.stage = SG_ADDR_W;
			ns.fail_flag = 1'b0;
			ns.phase = PH_ST0;
			ns.delay_left = 8'd0;
		end else if (item.mode == MODE_WBYTE && st.phase == PH_WAIT_BYTE) begin
			ns.shift_byte = item.write_byte;
			ns.bit_index = 4'd0;
			ns.phase = PH_TX_SET;
			ns.delay_left = 8'd0;
		end else if (item.mode == MODE_TICK && st.phase != PH_IDLE) begin
			if (st.delay_left != 8'd0) begin
				ns.delay_left = st.delay_left - 8'd1;
			end else begin
				case (st.phase)
					PH_ST0: begin
						ns.scl_level = 1'b1;
						ns.sda_level = 1'b1;
						ns = go_to(ns, PH_ST1, reload);
					end
					PH_ST1: begin
						ns.sda_level = 1'b0;
						ns = go_to(ns, PH_ST2, reload);
					end
					PH_ST2: begin
						ns.scl_level = 1'b0;
						ns.bit_index = 4'd0;
						ns = go_to(ns, PH_TX_SET, reload);
					end
					PH_TX_SET: begin
						ns.scl_level = 1'b0;
						ns.sda_level = st.shift_byte[7];
						ns = go_to(ns, PH_TX_HI, reload);
					end
					PH_TX_HI: begin
						ns.scl_level = 1'b1;
						ns = go_to(ns, PH_TX_LO, reload);
					end
					PH_TX_LO: begin
						ns.scl_level = 1'b0;
						ns.shift_byte = {st.shift_byte[6:0], 1'b0};
						ns.bit_index = bit_inc;
						ns = go_to(ns, (bit_inc >= 4'd8) ? PH_AK_REL : PH_TX_SET, reload);
					end
					PH_AK_REL: begin
						ns.scl_level = 1'b0;
						ns.sda_level = 1'b1;
						ns = go_to(ns, PH_AK_HI, reload);
					end
					PH_AK_HI: begin
						ns.scl_level = 1'b1;
						ns.ack_polls = 10'd0;
						ns = go_to(ns, PH_AK_POLL, reload);
					end
					PH_AK_POLL: begin
						if (!item.sda_in) begin
							// ACK seen: pick the next byte of the transfer
							ns.scl_level = 1'b0;
							case (st.stage)
								SG_ADDR_W: begin
									ns.shift_byte = st.held_register[15:8];
									ns.bit_index = 4'd0;
									ns.stage = SG_REG_HI;
									ns = go_to(ns, PH_TX_SET, reload);
								end
								SG_REG_HI: begin
									ns.shift_byte = st.held_register[7:0];
									ns.bit_index = 4'd0;
									ns.stage = SG_REG_LO;
									ns = go_to(ns, PH_TX_SET, reload);
								end
								SG_REG_LO: begin
									if (st.read_flag) begin
										ns.shift_byte = {cfg.slave_address, 1'b1};
										ns.stage = SG_ADDR_R;
										ns = go_to(ns, PH_ST0, reload);
									end else begin
										ns.stage = SG_DATA_W;
										ns = go_to(ns, (st.bytes_left != 8'd0) ?
											PH_WAIT_BYTE : PH_SP0, reload);
									end
								end
								SG_DATA_W: begin
									ns.bytes_left = bytes_dec;
									ns = go_to(ns, (bytes_dec != 8'd0) ?
										PH_WAIT_BYTE : PH_SP0, reload);
								end
								SG_ADDR_R: begin
									ns.stage = SG_DATA_R;
									ns.bit_index = 4'd0;
									ns = go_to(ns, (st.bytes_left != 8'd0) ?
										PH_RX_LO : PH_SP0, reload);
								end
								default: begin
									ns = go_to(ns, PH_SP0, reload);
								end
							endcase
						end else if (st.ack_polls >= cfg.ack_timeout) begin
							// Timeout: go straight to the stop
							ns.fail_flag = 1'b1;
							ns.phase = PH_SP0;
							ns.delay_left = 8'd0;
						end else begin
							ns.ack_polls = st.ack_polls + 10'd1;
						end
					end
					PH_WAIT_BYTE: begin
						ns = st;
					end
					PH_RX_LO: begin
						ns.scl_level = 1'b0;
						ns.sda_level = 1'b1;
						ns = go_to(ns, PH_RX_HI, reload);
					end
					PH_RX_HI: begin
						ns.scl_level = 1'b1;
						ns = go_to(ns, PH_RX_SMP, reload);
					end
					PH_RX_SMP: begin
						ns.shift_byte = rx_shift;
						ns.bit_index = bit_inc;
						ns = go_to(ns, (bit_inc >= 4'd8) ? PH_MA0 : PH_RX_LO, reload);
					end
					PH_MA0: begin
						// Deliver the byte, ACK unless it is the last one
						rb_valid = 1'b1;
						rb_data = st.shift_byte;
						ns.scl_level = 1'b0;
						ns.sda_level = (st.bytes_left > 8'd1) ? 1'b0 : 1'b1;
						ns = go_to(ns, PH_MA1, reload);
					end
					PH_MA1: begin
						ns.scl_level = 1'b1;
						ns = go_to(ns, PH_MA2, reload);
					end
					PH_MA2: begin
						ns.scl_level = 1'b0;
						ns.sda_level = 1'b0;
						ns.bytes_left = bytes_dec;
						ns.bit_index = 4'd0;
						ns = go_to(ns, (bytes_dec != 8'd0) ? PH_RX_LO : PH_SP0, reload);
					end
					PH_SP0: begin
						ns.scl_level = 1'b0;
						ns.sda_level = 1'b0;
						ns = go_to(ns, PH_SP1, reload);
					end
					PH_SP1: begin
						ns.scl_level = 1'b1;
						ns = go_to(ns, PH_SP2, reload);
					end
					PH_SP2: begin
						ns.sda_level = 1'b1;
						ns = go_to(ns, PH_SP_END, reload);
					end
					PH_SP_END: begin
						done = 1'b1;
						fail = st.fail_flag;
						ns.fail_flag = 1'b0;
						ns.phase = PH_IDLE;
						ns.delay_left = 8'd0;
					end
					default: begin
						ns.phase = PH_IDLE;
						ns.delay_left = 8'd0;
					end
				endcase
			end
		end
	end

	// Result seen after this beat
	always_comb begin
		res.scl = ns.scl_level;
		res.sda_release = ns.sda_level;
		res.busy_res = (ns.phase != PH_IDLE);
		res.need_byte = (ns.phase == PH_WAIT_BYTE);
		res.read_byte = rb_data;
		res.read_valid = rb_valid;
		res.done_res = done;
		res.failed = fail;
	end

endmodule

>>> sv/i2c_master_reg16_transfer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_reg16_transfer_top
// Pin-level I2C master for targets with 16-bit register addresses. Every
// input beat is a tick (with a sampled SDA level), a start command or a write
// byte, and each beat yields exactly one result beat carrying the SCL and SDA
// drive levels and the transfer status. The block takes one beat per cycle
// while the result is not stalled; a beat is captured in an input register
// and its result is loaded into the result register once that register is free,
// with the sequencer state updated in the same step. A stalled result holds
// the input register, which drops in_ready until the result beat is taken.
// Each pin action lasts phase_ticks ticks; configuration writes go straight
// into the registers and are meant for idle periods.
// ----------------------------------------------------------------------------
module i2c_master_reg16_transfer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [9:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        sda_in,
	input  logic        is_read,
	input  logic [15:0] register_address,
	input  logic [7:0]  byte_count,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl,
	output logic        sda_release,
	output logic        busy_res,
	output logic        need_byte,
	output logic [7:0]  read_byte,
	output logic        read_valid,
	output logic        done_res,
	output logic        failed
);
	import i2cm_pkg::*;

	cfg_t   cfg_q;
	item_t  item_s1;
	logic   valid_s1;
	state_t state_q;
	state_t state_nxt;
	res_t   res_nxt;
	res_t   res_q;
	logic   out_valid_q;
	logic   advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= 7'd0;
			cfg_q.phase_ticks <= PHASE_TICKS_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SLAVE_ADDRESS: cfg_q.slave_address <= cfg_wdata[6:0];
				CFG_PHASE_TICKS:   cfg_q.phase_ticks <= cfg_wdata[7:0];
				CFG_ACK_TIMEOUT:   cfg_q.ack_timeout <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Move the held beat on when the result register is free
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{mode: mode, sda_in: sda_in, is_read: is_read,
				register_address: register_address, byte_count: byte_count,
				write_byte: write_byte};
		end
	end

	i2cm_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.st   (state_q),
		.ns   (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign scl         = res_q.scl;
	assign sda_release = res_q.sda_release;
	assign busy_res    = res_q.busy_res;
	assign need_byte   = res_q.need_byte;
	assign read_byte   = res_q.read_byte;
	assign read_valid  = res_q.read_valid;
	assign done_res    = res_q.done_res;
	assign failed      = res_q.failed;

endmodule
